// File: rtl/core/fmd_pkg.sv
// ----------------------------------------------------------------------------
// fmd_pkg
// Shared types, character codes, event codes and helpers of the framed
// message decoder.
// ----------------------------------------------------------------------------
package fmd_pkg;

  localparam int VALUE_WIDTH_DEF = 16;
  localparam int OUT_WIDTH       = 16;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = 8;

  // register indexes of the configuration port
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_IDX_MAX_PAYLOAD  = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_IDX_MAX_CHECKSUM = 2'd1;

  localparam logic [7:0] MAX_PAYLOAD_RST  = 8'd32;
  localparam logic [3:0] MAX_CHECKSUM_RST = 4'd2;

  // characters
  localparam logic [7:0] CH_START   = 8'h24;  // '$'
  localparam logic [7:0] CH_STAR    = 8'h2A;  // '*'
  localparam logic [7:0] CH_NL      = 8'h0A;  // newline
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] HEX_ALPHA_OFS = 8'd55;
  localparam logic [7:0] HEX_DIGIT_OFS = 8'd48;

  // type tokens
  localparam logic [23:0] TOK_CHA = 24'h434841;
  localparam logic [23:0] TOK_ACC = 24'h414343;
  localparam logic [23:0] TOK_REV = 24'h524556;
  localparam logic [23:0] TOK_SHO = 24'h53484F;
  localparam logic [23:0] TOK_RES = 24'h524553;

  // event kinds
  localparam logic [2:0] KIND_CHA   = 3'd0;
  localparam logic [2:0] KIND_ACC   = 3'd1;
  localparam logic [2:0] KIND_REV   = 3'd2;
  localparam logic [2:0] KIND_SHO   = 3'd3;
  localparam logic [2:0] KIND_RES   = 3'd4;
  localparam logic [2:0] KIND_ERROR = 3'd5;

  // error codes
  localparam logic [2:0] ERR_NONE          = 3'd0;
  localparam logic [2:0] ERR_PAYLOAD_LONG  = 3'd0;
  localparam logic [2:0] ERR_BAD_TYPE      = 3'd1;
  localparam logic [2:0] ERR_CHECKSUM_LONG = 3'd2;
  localparam logic [2:0] ERR_CHECKSUM_SHORT = 3'd3;
  localparam logic [2:0] ERR_BAD_CHECKSUM  = 3'd4;

  typedef struct packed {
    logic [7:0] max_payload_len;
    logic [3:0] max_checksum_len;
  } cfg_t;

  typedef struct packed {
    logic started;
    logic neg;
    logic stopped;
  } field_flags_t;

  typedef struct packed {
    logic                 valid;
    logic [2:0]           event_kind;
    logic [2:0]           error_code;
    logic [OUT_WIDTH-1:0] value_a;
    logic [OUT_WIDTH-1:0] value_b;
    logic [OUT_WIDTH-1:0] value_c;
  } result_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // no validation: upper-case letters map as c-55, everything else as c-48
  function automatic logic [7:0] hex_digit(input logic [7:0] c);
    if ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) begin
      return c - HEX_ALPHA_OFS;
    end
    return c - HEX_DIGIT_OFS;
  endfunction

  // {hit, kind}
  function automatic logic [3:0] token_kind(input logic [23:0] tok);
    case (tok)
      TOK_CHA: return {1'b1, KIND_CHA};
      TOK_ACC: return {1'b1, KIND_ACC};
      TOK_REV: return {1'b1, KIND_REV};
      TOK_SHO: return {1'b1, KIND_SHO};
      TOK_RES: return {1'b1, KIND_RES};
      default: return {1'b0, KIND_ERROR};
    endcase
  endfunction

endpackage

// File: rtl/core/fmd_field.sv
// ----------------------------------------------------------------------------
// fmd_field
// One character step of the decimal field converter: skips leading white
// space, takes an optional sign, then accumulates digits modulo 2^VALUE_WIDTH.
// ----------------------------------------------------------------------------
module fmd_field #(
  parameter int VALUE_WIDTH = fmd_pkg::VALUE_WIDTH_DEF
) (
  input  logic [7:0]             char_in,
  input  fmd_pkg::field_flags_t  flags_in,
  input  logic [VALUE_WIDTH-1:0] value_in,
  output fmd_pkg::field_flags_t  flags_out,
  output logic [VALUE_WIDTH-1:0] value_out
);
  import fmd_pkg::*;

  logic                   digit;
  logic [VALUE_WIDTH-1:0] digit_val;
  logic [VALUE_WIDTH-1:0] times_ten;

  assign digit     = is_digit(char_in);
  assign digit_val = VALUE_WIDTH'(char_in[3:0]);
  // x*10 as two shifts and an add
  assign times_ten = (value_in << 3) + (value_in << 1);

  always_comb begin
    flags_out = flags_in;
    value_out = value_in;
    if (!flags_in.stopped) begin
      if (!flags_in.started) begin
        if (is_space(char_in)) begin
          flags_out = flags_in;
        end else if ((char_in == CH_PLUS) || (char_in == CH_MINUS)) begin
          flags_out.started = 1'b1;
          if (char_in == CH_MINUS) begin
            flags_out.neg = 1'b1;
          end
        end else if (digit) begin
          flags_out.started = 1'b1;
          value_out         = digit_val;
        end else begin
          flags_out.stopped = 1'b1;
        end
      end else if (digit) begin
        value_out = times_ten + digit_val;
      end else begin
        flags_out.stopped = 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/fmd_parser.sv
// ----------------------------------------------------------------------------
// fmd_parser
// Frame state and per-byte decision logic: phase, counts, running xor,
// type token, decimal fields and checksum characters, and the event or
// error a byte closes.
// ----------------------------------------------------------------------------
module fmd_parser #(
  parameter int VALUE_WIDTH = fmd_pkg::VALUE_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       char_in,
  input  fmd_pkg::cfg_t    cfg,
  output fmd_pkg::result_t res
);
  import fmd_pkg::*;

  typedef enum logic [2:0] {
    PH_WAIT     = 3'b001,
    PH_PAYLOAD  = 3'b010,
    PH_CHECKSUM = 3'b100
  } phase_t;

  phase_t                 phase, phase_next;
  logic [7:0]             payload_count, payload_count_next;
  logic [7:0]             running_xor, running_xor_next;
  logic [23:0]            type_token, type_token_next;
  logic                   type_token_bad, type_token_bad_next;
  logic [1:0]             field_number, field_number_next;
  logic [VALUE_WIDTH-1:0] field_values [3];
  logic [VALUE_WIDTH-1:0] field_values_next [3];
  field_flags_t           field_flags [3];
  field_flags_t           field_flags_next [3];
  logic [3:0]             checksum_count, checksum_count_next;
  logic [7:0]             checksum_chars [2];
  logic [7:0]             checksum_chars_next [2];

  logic [VALUE_WIDTH-1:0] cur_value, upd_value;
  field_flags_t           cur_flags, upd_flags;
  logic [OUT_WIDTH-1:0]   field_out [3];
  logic [7:0]             pc_inc;
  logic [7:0]             given;
  logic [3:0]             tok_hit_kind;
  logic                   type_ok;
  logic                   clear;
  logic                   start;

  // the shared converter works on the field being filled
  always_comb begin
    case (field_number)
      2'd2:    begin cur_value = field_values[1]; cur_flags = field_flags[1]; end
      2'd3:    begin cur_value = field_values[2]; cur_flags = field_flags[2]; end
      default: begin cur_value = field_values[0]; cur_flags = field_flags[0]; end
    endcase
  end

  fmd_field #(.VALUE_WIDTH(VALUE_WIDTH)) u_field (
    .char_in   (char_in),
    .flags_in  (cur_flags),
    .value_in  (cur_value),
    .flags_out (upd_flags),
    .value_out (upd_value)
  );

  // negate at the field width first, then fit to the output width
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      field_out[i] = field_flags[i].neg ? OUT_WIDTH'(VALUE_WIDTH'(-field_values[i]))
                                        : OUT_WIDTH'(field_values[i]);
    end
  end

  assign pc_inc       = (payload_count == 8'hFF) ? payload_count : payload_count + 8'd1;
  assign given        = (hex_digit(checksum_chars[0]) << 4) + hex_digit(checksum_chars[1]);
  assign tok_hit_kind = token_kind(type_token);
  assign type_ok      = !type_token_bad && ((field_number != 2'd0) || (payload_count == 8'd3));

  always_comb begin
    phase_next          = phase;
    payload_count_next  = payload_count;
    running_xor_next    = running_xor;
    type_token_next     = type_token;
    type_token_bad_next = type_token_bad;
    field_number_next   = field_number;
    field_values_next   = field_values;
    field_flags_next    = field_flags;
    checksum_count_next = checksum_count;
    checksum_chars_next = checksum_chars;
    res                 = '0;
    clear               = 1'b0;
    start               = 1'b0;

    case (phase)
      PH_PAYLOAD: begin
        if (payload_count > cfg.max_payload_len) begin
          res.valid      = 1'b1;
          res.event_kind = KIND_ERROR;
          res.error_code = ERR_PAYLOAD_LONG;
          clear          = 1'b1;
        end else if ((char_in == CH_START) || (char_in == CH_NL)) begin
          res.valid      = 1'b1;
          res.event_kind = KIND_ERROR;
          res.error_code = ERR_BAD_TYPE;
          clear          = 1'b1;
        end else if (char_in == CH_STAR) begin
          phase_next = PH_CHECKSUM;
        end else begin
          payload_count_next = pc_inc;
          running_xor_next   = running_xor ^ char_in;
          if (char_in == CH_COMMA) begin
            if (field_number == 2'd0) begin
              if (pc_inc != 8'd4) begin
                type_token_bad_next = 1'b1;
              end
              field_number_next = 2'd1;
            end else if (field_number != 2'd3) begin
              field_number_next = field_number + 2'd1;
            end else begin
              field_flags_next[2].stopped = 1'b1;
            end
          end else if (field_number == 2'd0) begin
            if (pc_inc <= 8'd3) begin
              type_token_next = {type_token[15:0], char_in};
            end else begin
              type_token_bad_next = 1'b1;
            end
          end else begin
            case (field_number)
              2'd2: begin
                field_values_next[1] = upd_value;
                field_flags_next[1]  = upd_flags;
              end
              2'd3: begin
                field_values_next[2] = upd_value;
                field_flags_next[2]  = upd_flags;
              end
              default: begin
                field_values_next[0] = upd_value;
                field_flags_next[0]  = upd_flags;
              end
            endcase
          end
        end
      end
      PH_CHECKSUM: begin
        if (checksum_count > cfg.max_checksum_len) begin
          res.valid      = 1'b1;
          res.event_kind = KIND_ERROR;
          res.error_code = ERR_CHECKSUM_LONG;
          clear          = 1'b1;
        end else if (char_in == CH_NL) begin
          res.valid = 1'b1;
          clear     = 1'b1;
          if (checksum_count < 4'd2) begin
            res.event_kind = KIND_ERROR;
            res.error_code = ERR_CHECKSUM_SHORT;
          end else if (!(type_ok && tok_hit_kind[3])) begin
            // unknown type wins over a bad checksum
            res.event_kind = KIND_ERROR;
            res.error_code = ERR_BAD_TYPE;
          end else if (given != running_xor) begin
            res.event_kind = KIND_ERROR;
            res.error_code = ERR_BAD_CHECKSUM;
          end else begin
            res.event_kind = tok_hit_kind[2:0];
            res.error_code = ERR_NONE;
            res.value_a    = field_out[0];
            if ((tok_hit_kind[2:0] == KIND_SHO) || (tok_hit_kind[2:0] == KIND_RES)) begin
              res.value_b = field_out[1];
            end
            if (tok_hit_kind[2:0] == KIND_RES) begin
              res.value_c = field_out[2];
            end
          end
        end else begin
          if (checksum_count == 4'd0) begin
            checksum_chars_next[0] = char_in;
          end else if (checksum_count == 4'd1) begin
            checksum_chars_next[1] = char_in;
          end
          if (checksum_count != 4'hF) begin
            checksum_count_next = checksum_count + 4'd1;
          end
        end
      end
      default: begin
        if (char_in == CH_START) begin
          clear = 1'b1;
          start = 1'b1;
        end else begin
          phase_next = PH_WAIT;
        end
      end
    endcase

    if (clear) begin
      phase_next          = start ? PH_PAYLOAD : PH_WAIT;
      payload_count_next  = '0;
      running_xor_next    = '0;
      type_token_next     = '0;
      type_token_bad_next = 1'b0;
      field_number_next   = '0;
      checksum_count_next = '0;
      for (int i = 0; i < 3; i++) begin
        field_values_next[i] = '0;
        field_flags_next[i]  = '0;
      end
      checksum_chars_next[0] = '0;
      checksum_chars_next[1] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_WAIT;
      payload_count  <= '0;
      running_xor    <= '0;
      type_token     <= '0;
      type_token_bad <= 1'b0;
      field_number   <= '0;
      checksum_count <= '0;
      for (int i = 0; i < 3; i++) begin
        field_values[i] <= '0;
        field_flags[i]  <= '0;
      end
      checksum_chars[0] <= '0;
      checksum_chars[1] <= '0;
    end else if (step) begin
      phase          <= phase_next;
      payload_count  <= payload_count_next;
      running_xor    <= running_xor_next;
      type_token     <= type_token_next;
      type_token_bad <= type_token_bad_next;
      field_number   <= field_number_next;
      checksum_count <= checksum_count_next;
      field_values   <= field_values_next;
      field_flags    <= field_flags_next;
      checksum_chars <= checksum_chars_next;
    end
  end

  // every event or error leaves the frame cleared and waiting for a start
  a_clear_after_result: assert property (@(posedge clk) disable iff (rst)
    (step && res.valid) |=> (phase == PH_WAIT) && (payload_count == 8'd0)
                            && (checksum_count == 4'd0))
    else $error("parser not cleared after a result");

endmodule

// File: rtl/core/framed_message_decoder.sv
// ----------------------------------------------------------------------------
// framed_message_decoder
// Byte-serial decoder of '$' payload '*' checksum newline frames with xor
// checksum, type token and up to three decimal fields.
//
// channel  dir  handshake            payload
// s_*      in   s_tvalid/s_tready    s_tdata: in_byte
// m_*      out  m_tvalid/m_tready    m_tuser: event_kind; m_tdata: error_code, values
// cfg_*    in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one byte is taken per cycle while s_tready is high; a byte is decoded in
// the cycle it is accepted and a result appears in the output register on
// the following cycle. s_tready is low only while a result waits in the
// output register and m_tready is low; a result is registered in the
// output register only, not in the parser state. cfg_ready is always high.
// synchronous reset clears the frame state, the output valid and restores
// the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module framed_message_decoder #(
  parameter int VALUE_WIDTH = fmd_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [7:0]                           s_tdata,   // [7:0] in_byte
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // [2:0] error_code, [18:3] value_a, [34:19] value_b, [50:35] value_c
  output logic [55:0]                          m_tdata,
  output logic [2:0]                           m_tuser,   // [2:0] event_kind
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [fmd_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [fmd_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);
  import fmd_pkg::*;

  cfg_t    cfg;
  result_t res;
  logic    step;

  logic [2:0]           out_kind;
  logic [2:0]           out_code;
  logic [OUT_WIDTH-1:0] out_a, out_b, out_c;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_payload_len  <= MAX_PAYLOAD_RST;
      cfg.max_checksum_len <= MAX_CHECKSUM_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IDX_MAX_PAYLOAD:  cfg.max_payload_len  <= cfg_data;
        CFG_IDX_MAX_CHECKSUM: cfg.max_checksum_len <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign s_tready = !m_tvalid || m_tready;
  assign step     = s_tvalid && s_tready;

  fmd_parser #(.VALUE_WIDTH(VALUE_WIDTH)) u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .char_in (s_tdata),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step && res.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.valid) begin
      out_kind <= res.event_kind;
      out_code <= res.error_code;
      out_a    <= res.value_a;
      out_b    <= res.value_b;
      out_c    <= res.value_c;
    end
  end

  assign m_tuser = out_kind;
  assign m_tdata = {5'd0, out_c, out_b, out_a, out_code};

  a_error_values_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == KIND_ERROR)) |-> (m_tdata[50:3] == '0))
    else $error("error word carries nonzero values");

  a_event_code_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != KIND_ERROR)) |-> (m_tdata[2:0] == ERR_NONE))
    else $error("event word carries an error code");

  a_value_c_res_only: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != KIND_RES)) |-> (m_tdata[50:35] == '0))
    else $error("third value set outside a three-value event");

  a_valid_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser <= KIND_ERROR))
    else $error("event kind out of range");

endmodule
